[src/lpt_pkg.sv]
// shared types and constants of the latency pair tracker
package lpt_pkg;

  // request opcodes
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_END    = 2'd1;
  localparam logic [1:0] OP_SWITCH = 2'd2;

  // event kind reported for a closed block interval
  localparam logic [2:0] KIND_SWITCH = 3'd7;

  // entry status codes
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_VALID = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  // register file
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_LAT   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_KIND_MASK = 1'b1;
  localparam logic [31:0] MIN_LAT_RESET   = 32'd1000000;
  localparam logic [7:0]  KIND_MASK_RESET = 8'd240;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        process_id;
    logic [31:0]        thread_id;
    logic [31:0]        next_process_id;
    logic [2:0]         event_kind_in;
    logic signed [31:0] return_code;
    logic [63:0]        now_ns;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        event_time_ns;
    logic [31:0]        event_process_id;
    logic [2:0]         event_kind;
    logic [63:0]        event_latency;
    logic signed [31:0] error_code;
  } out_item_t;

  typedef struct packed {
    logic [31:0] min_latency_ns;
    logic [7:0]  filtered_kind_mask;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] key;
    logic [63:0] start_ns;
  } entry_t;

endpackage

[src/latency_pair_tracker_unit.sv]
// top level of the latency pair tracker: registers, table controller, event register
//
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  req_item   (begin, end or switch request)
//  evt       out        evt_valid/evt_stall  evt_item   (latency event)
//  apb       in         psel/penable/pready  paddr, pwdata, prdata
//
// after reset a clearing pass walks every entry of the table with req_stall high
// a request goes through the start and probe states, a found close also through eval; one probe
// per entry of the chain, at most TABLE_ENTRIES probes; a switch with both processes set does two lookups
// one table ram with one write and one registered read port sets the probe rate
// an event waits in the controller while the output register is held by evt_stall;
// the next request is taken while a finished event still sits in that register
module latency_pair_tracker_unit #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  lpt_pkg::in_item_t           req_item,
  output logic                        evt_valid,
  input  logic                        evt_stall,
  output lpt_pkg::out_item_t          evt_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lpt_pkg::*;

  cfg_t      cfg;
  logic      evt_free;
  logic      evt_load;
  out_item_t evt_next;

  // threshold and kind mask
  lpt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // table of open operations, hashed with linear probing and tombstones
  lpt_ctrl #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .cfg       (cfg),
    .evt_free  (evt_free),
    .evt_load  (evt_load),
    .evt_next  (evt_next)
  );

  // output register: free when empty or being taken this cycle
  assign evt_free = !evt_valid || !evt_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (evt_load) begin
      evt_valid <= 1'b1;
    end else if (!evt_stall) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_load) begin
      evt_item <= evt_next;
    end
  end

  // an event never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    evt_load |-> !(evt_valid && evt_stall))
    else $error("event loaded into a held output register");

  // the clearing pass holds off requests straight after reset
  a_clear_stall: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken during the clearing pass");

  // an event is only produced while a request is in flight
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    evt_load |-> req_stall)
    else $error("event produced with the controller idle");

endmodule

[src/lpt_ram.sv]
// generic simple dual-port ram with registered read
module lpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/lpt_regs.sv]
// apb configuration registers
module lpt_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpt_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output lpt_pkg::cfg_t                cfg
);
  import lpt_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_latency_ns     <= MIN_LAT_RESET;
      cfg.filtered_kind_mask <= KIND_MASK_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MIN_LAT: begin
          cfg.min_latency_ns <= pwdata;
        end
        REG_KIND_MASK: begin
          cfg.filtered_kind_mask <= pwdata[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_LAT:   prdata = cfg.min_latency_ns;
      REG_KIND_MASK: prdata = {24'd0, cfg.filtered_kind_mask};
      default:       prdata = '0;
    endcase
  end

endmodule

[src/lpt_ctrl.sv]
// hashed table controller: probe, read-modify-write and event decision
module lpt_ctrl #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  lpt_pkg::in_item_t  req_item,
  input  lpt_pkg::cfg_t      cfg,
  input  logic               evt_free,
  output logic               evt_load,
  output lpt_pkg::out_item_t evt_next
);
  import lpt_pkg::*;

  localparam int unsigned     AW       = $clog2(ENTRIES);
  localparam logic [AW-1:0]   LAST_IDX = AW'(ENTRIES - 1);
  localparam logic [AW:0]     DEPTH_W  = (AW + 1)'(ENTRIES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;

  localparam logic [1:0] M_OPEN     = 2'd0;
  localparam logic [1:0] M_CLOSE_END = 2'd1;
  localparam logic [1:0] M_CLOSE_SW = 2'd2;

  // xor fold of the key onto a home slot
  function automatic logic [AW-1:0] home_index(input logic [63:0] k);
    logic [31:0]   f32;
    logic [15:0]   f16;
    logic [AW-1:0] h;
    f32 = k[63:32] ^ {k[15:0], k[31:16]};
    f16 = f32[31:16] ^ f32[15:0];
    h   = f16[AW-1:0];
    if ({1'b0, h} >= DEPTH_W) begin
      h = h - DEPTH_W[AW-1:0];
    end
    return h;
  endfunction

  logic [2:0]         state;
  logic [1:0]         mode;
  logic [AW-1:0]      clr_addr;
  logic [63:0]        key;
  logic [63:0]        now;
  logic [31:0]        pid;
  logic [31:0]        nxt;
  logic [2:0]         kind;
  logic signed [31:0] rc;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      cnt;
  logic               free_found;
  logic [AW-1:0]      free_idx;
  logic [63:0]        lat;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  entry_t             wdata;
  entry_t             rd;

  logic               hit;
  logic               cur_free;
  logic               chain_end;
  logic [AW-1:0]      idx_inc;
  logic               is_open;
  logic               ins_ok;
  logic [AW-1:0]      ins_idx;
  logic               filtered;
  logic [63:0]        thr;
  logic               pass;
  logic               more_open;
  logic               close_done;
  logic               to_next_open;

  lpt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  assign hit       = (rd.status == ST_VALID) && (rd.key == key);
  assign cur_free  = rd.status != ST_VALID;
  assign chain_end = (rd.status == ST_EMPTY) || (cnt == LAST_IDX);
  assign idx_inc   = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign is_open   = mode == M_OPEN;
  assign ins_ok    = free_found || cur_free;
  assign ins_idx   = free_found ? free_idx : idx;
  assign filtered  = cfg.filtered_kind_mask[kind];
  assign thr       = {32'd0, cfg.min_latency_ns};
  assign pass      = (mode == M_CLOSE_SW) ? (lat > thr) : (!filtered || (lat >= thr));
  assign more_open = (mode == M_CLOSE_SW) && (nxt != 32'd0);

  // a close finishes on a miss or once its event is decided
  assign close_done = ((state == S_PROBE) && !hit && chain_end && !is_open) ||
                      ((state == S_EVAL) && (!pass || evt_free));
  assign to_next_open = close_done && more_open;

  assign req_stall = state != S_IDLE;
  assign evt_load  = (state == S_EVAL) && pass && evt_free;

  always_comb begin
    evt_next.event_time_ns    = now;
    evt_next.event_process_id = pid;
    evt_next.event_kind       = (mode == M_CLOSE_SW) ? KIND_SWITCH : kind;
    evt_next.event_latency    = lat;
    evt_next.error_code       = (mode == M_CLOSE_SW) ? 32'sd0 : rc;
  end

  always_comb begin
    we             = 1'b0;
    waddr          = idx;
    raddr          = idx;
    wdata.status   = ST_VALID;
    wdata.key      = key;
    wdata.start_ns = now;
    case (state)
      S_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_addr;
        wdata.status = ST_EMPTY;
      end
      S_START: begin
        raddr = home_index(key);
      end
      S_PROBE: begin
        if (hit) begin
          we = 1'b1;
          if (!is_open) begin
            wdata.status = ST_TOMB;
          end
        end else if (chain_end) begin
          if (is_open && ins_ok) begin
            we    = 1'b1;
            waddr = ins_idx;
          end
        end else begin
          raddr = idx_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      mode     <= M_OPEN;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= (clr_addr == LAST_IDX) ? '0 : clr_addr + 1'b1;
          if (clr_addr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            case (req_item.opcode)
              OP_BEGIN: begin
                mode  <= M_OPEN;
                state <= S_START;
              end
              OP_END: begin
                mode  <= M_CLOSE_END;
                state <= S_START;
              end
              OP_SWITCH: begin
                if (req_item.process_id != 32'd0) begin
                  mode  <= M_CLOSE_SW;
                  state <= S_START;
                end else if (req_item.next_process_id != 32'd0) begin
                  mode  <= M_OPEN;
                  state <= S_START;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_START: begin
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (hit) begin
            state <= is_open ? S_IDLE : S_EVAL;
          end else if (chain_end) begin
            if (to_next_open) begin
              mode  <= M_OPEN;
              state <= S_START;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EVAL: begin
          if (close_done) begin
            if (to_next_open) begin
              mode  <= M_OPEN;
              state <= S_START;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && req_valid) begin
      pid  <= req_item.process_id;
      nxt  <= req_item.next_process_id;
      kind <= req_item.event_kind_in;
      rc   <= req_item.return_code;
      now  <= req_item.now_ns;
      if (req_item.opcode != OP_SWITCH) begin
        key <= {req_item.process_id, req_item.thread_id};
      end else if (req_item.process_id != 32'd0) begin
        key <= {req_item.process_id, 32'd0};
      end else begin
        key <= {req_item.next_process_id, 32'd0};
      end
    end else if (to_next_open) begin
      key <= {nxt, 32'd0};
    end
    if (state == S_START) begin
      idx        <= home_index(key);
      cnt        <= '0;
      free_found <= 1'b0;
    end
    if (state == S_PROBE) begin
      if (hit) begin
        lat <= (now > rd.start_ns) ? now - rd.start_ns : 64'd0;
      end else if (!chain_end) begin
        idx <= idx_inc;
        cnt <= cnt + 1'b1;
        if (!free_found && cur_free) begin
          free_found <= 1'b1;
          free_idx   <= idx;
        end
      end
    end
  end

endmodule

[tb/testbench.sv]
// self-checking testbench of the latency pair tracker: register, directed, random and full-table tests
module testbench;
  import lpt_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 1024;
  // opcode value that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // slowest request: two full probe walks plus the other states; also covers the clearing pass
  localparam int unsigned DRAIN_CYCLES = 2 * TABLE_ENTRIES + 32;
  // worst run: every request probing twice through the table and waiting on long stalls
  localparam longint unsigned LIMIT_CYCLES = 64'd20_000_000;
  localparam int unsigned PHASE_ITEMS = 110;

  logic               clk;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  in_item_t           req_item = '0;
  logic               evt_valid;
  logic               evt_stall = 1'b0;
  out_item_t          evt_item;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  latency_pair_tracker_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
    .evt_valid(evt_valid), .evt_stall(evt_stall), .evt_item(evt_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // own copy of the block's state: open intervals keyed by {process, thread}
  logic [63:0] open_start [logic [63:0]];
  logic [31:0] cfg_min_latency = MIN_LAT_RESET;
  logic [7:0]  cfg_kind_mask = KIND_MASK_RESET;
  // latency events still owed by the block, oldest first
  out_item_t   expected_events [$];

  int          failures = 0;
  int          requests_sent = 0;
  int          events_checked = 0;
  int          settings_applied = 1;
  longint unsigned cycle_count = 0;

  // idling controls and random content pools
  bit          sender_idles = 1'b0;
  bit          receiver_stalls = 1'b0;
  int          stall_left = 0;
  logic [63:0] clock_ns = 64'd0;
  logic [31:0] pid_pool [8];
  logic [31:0] tid_pool [4];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: run limit of %0d cycles reached", $time, LIMIT_CYCLES);
      $display("tb: failure");
      $finish;
    end
  end

  // receiver back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk) begin
    if (stall_left > 0) begin
      evt_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
      evt_stall <= 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      evt_stall <= 1'b0;
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // every accepted event is compared against the oldest owed one
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && evt_valid && !evt_stall) begin
      if (expected_events.size() == 0) begin
        failures++;
        $display("%0t: unexpected event, expected none, actual pid %h kind %0d lat %h",
                 $time, evt_item.event_process_id, evt_item.event_kind, evt_item.event_latency);
      end else begin
        want = expected_events.pop_front();
        events_checked++;
        check_field("event_time_ns", want.event_time_ns, evt_item.event_time_ns);
        check_field("event_process_id", 64'(want.event_process_id),
                    64'(evt_item.event_process_id));
        check_field("event_kind", 64'(want.event_kind), 64'(evt_item.event_kind));
        check_field("event_latency", want.event_latency, evt_item.event_latency);
        check_field("error_code", 64'(want.error_code), 64'(evt_item.error_code));
      end
    end
  end

  // ---------------------------------------------------------------- prediction

  // elapsed time, clamped at zero when the clock went backward
  function automatic logic [63:0] elapsed_ns(logic [63:0] start, logic [63:0] now);
    return (now > start) ? now - start : 64'd0;
  endfunction

  // store or refresh an interval; a new key is dropped when the table is full
  function automatic void open_interval(logic [63:0] key, logic [63:0] now);
    if (open_start.exists(key) || open_start.num() < TABLE_ENTRIES)
      open_start[key] = now;
  endfunction

  function automatic void predict_request(in_item_t r);
    logic [63:0] key;
    logic [63:0] lat;
    out_item_t   ev;
    ev.event_time_ns    = r.now_ns;
    ev.event_process_id = r.process_id;
    case (r.opcode)
      OP_BEGIN: open_interval({r.process_id, r.thread_id}, r.now_ns);
      OP_END: begin
        key = {r.process_id, r.thread_id};
        if (open_start.exists(key)) begin
          lat = elapsed_ns(open_start[key], r.now_ns);
          open_start.delete(key);
          // filtered kinds need at least the threshold
          if (!cfg_kind_mask[r.event_kind_in] || lat >= {32'd0, cfg_min_latency}) begin
            ev.event_kind    = r.event_kind_in;
            ev.event_latency = lat;
            ev.error_code    = r.return_code;
            expected_events.push_back(ev);
          end
        end
      end
      OP_SWITCH: begin
        // close the block interval of the outgoing process, strictly above threshold
        key = {r.process_id, 32'd0};
        if (r.process_id != 32'd0 && open_start.exists(key)) begin
          lat = elapsed_ns(open_start[key], r.now_ns);
          open_start.delete(key);
          if (lat > {32'd0, cfg_min_latency}) begin
            ev.event_kind    = KIND_SWITCH;
            ev.event_latency = lat;
            ev.error_code    = 32'sd0;
            expected_events.push_back(ev);
          end
        end
        if (r.next_process_id != 32'd0)
          open_interval({r.next_process_id, 32'd0}, r.now_ns);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic int pick_gap();
    int r;
    if (!sender_idles)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // valid stays high across back-to-back requests; it drops only for a gap or in wait_idle
  task automatic send_request(input in_item_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= r;
    do @(posedge clk); while (req_stall);
    predict_request(r);
    requests_sent++;
  endtask

  // hold off until every owed event is out, then let a slow request finish
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_MIN_LAT)
      cfg_min_latency = value;
    else
      cfg_kind_mask = value[7:0];
  endtask

  // read a register back and compare it with the predictor's copy
  task automatic apb_check(input logic [REG_IDX_W-1:0] idx);
    logic [31:0] got;
    logic [31:0] want;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'(idx) << 2;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_MIN_LAT) begin
      want = cfg_min_latency;
    end else begin
      want = {24'd0, cfg_kind_mask};
      got  = {24'd0, got[7:0]};
    end
    if (got !== want) begin
      failures++;
      $display("%0t: register %0d readback, expected %h, actual %h", $time, idx, want, got);
    end
  endtask

  task automatic set_config(input logic [31:0] min_lat, input logic [7:0] mask);
    wait_idle();
    apb_write(REG_MIN_LAT, min_lat);
    apb_write(REG_KIND_MASK, {24'd0, mask});
    apb_check(REG_MIN_LAT);
    apb_check(REG_KIND_MASK);
    settings_applied++;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic in_item_t make_request(logic [1:0] op, logic [31:0] pid, logic [31:0] tid,
                                            logic [31:0] nxt, logic [2:0] kind,
                                            logic [31:0] rc, logic [63:0] now);
    in_item_t r;
    r.opcode          = op;
    r.process_id      = pid;
    r.thread_id       = tid;
    r.next_process_id = nxt;
    r.event_kind_in   = kind;
    r.return_code     = rc;
    r.now_ns          = now;
    return r;
  endfunction

  // mostly forward, sometimes a wild jump or a step back
  function automatic logic [63:0] advance_clock();
    case ($urandom_range(0, 19))
      0:       clock_ns = {$urandom, $urandom};
      1:       clock_ns = clock_ns - 64'($urandom_range(1, 100000));
      default: clock_ns = clock_ns + 64'($urandom_range(1, 200000));
    endcase
    return clock_ns;
  endfunction

  // elapsed time aimed at the threshold edges, with some far and backward values
  function automatic logic [63:0] pick_elapsed();
    logic [63:0] m;
    m = {32'd0, cfg_min_latency};
    case ($urandom_range(0, 7))
      0:       return m - 64'd1;
      1:       return m;
      2:       return m + 64'd1;
      3:       return 64'($urandom_range(0, 3000));
      4:       return {$urandom, $urandom};
      5:       return 64'd0 - 64'($urandom_range(1, 1000));
      default: return m + 64'($urandom_range(0, 1 << 20));
    endcase
  endfunction

  function automatic void refresh_pools();
    foreach (pid_pool[i]) pid_pool[i] = $urandom;
    foreach (tid_pool[i]) tid_pool[i] = $urandom;
  endfunction

  // well-formed begin/end/switch traffic on a small key pool, plus noise
  function automatic in_item_t random_request();
    in_item_t    r;
    logic [63:0] key;
    int          pick;
    r = make_request(OP_BEGIN, pid_pool[$urandom_range(0, 7)],
                     ($urandom_range(0, 2) == 0) ? 32'd0 : tid_pool[$urandom_range(0, 3)],
                     32'd0, 3'($urandom_range(0, 7)), $urandom, advance_clock());
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      r.opcode = OP_BEGIN;
    end else if (pick < 70) begin
      r.opcode = OP_END;
      key = {r.process_id, r.thread_id};
      if (open_start.exists(key))
        r.now_ns = open_start[key] + pick_elapsed();
    end else if (pick < 88) begin
      r.opcode = OP_SWITCH;
      r.thread_id = $urandom;
      if ($urandom_range(0, 4) == 0)
        r.process_id = 32'd0;
      r.next_process_id = ($urandom_range(0, 3) == 0) ? 32'd0 : pid_pool[$urandom_range(0, 7)];
      key = {r.process_id, 32'd0};
      if (open_start.exists(key))
        r.now_ns = open_start[key] + pick_elapsed();
    end else begin
      // noise: every field random, unused opcode included
      r = make_request(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                       3'($urandom_range(0, 7)), $urandom, {$urandom, $urandom});
    end
    return r;
  endfunction

  task automatic run_random(input int count);
    int mode;
    for (int n = 0; n < count; n++) begin
      // idling pattern changes every few dozen requests, quiet stretches included
      if (n % 32 == 0) begin
        mode = $urandom_range(0, 3);
        sender_idles    = mode[0];
        receiver_stalls = mode[1];
      end
      send_request(random_request());
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_register_reset();
    apb_check(REG_MIN_LAT);
    apb_check(REG_KIND_MASK);
  endtask

  // corner cases under the reset threshold and kind mask
  task automatic test_directed();
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    // begin, overwrite, then an end with the clock behind the start: latency zero
    send_request(make_request(OP_BEGIN, 32'd1, 32'd2, 32'd0, 3'd0, 32'd0, 64'd100));
    send_request(make_request(OP_BEGIN, 32'd1, 32'd2, 32'd0, 3'd0, 32'd0, 64'd200));
    send_request(make_request(OP_END, 32'd1, 32'd2, 32'd0, 3'd0, -32'sd5, 64'd150));
    // key gone: nothing happens
    send_request(make_request(OP_END, 32'd1, 32'd2, 32'd0, 3'd0, 32'd1, 64'd300));
    // filtered kind one below the threshold: silent but deleted
    send_request(make_request(OP_BEGIN, 32'd3, 32'd4, 32'd0, 3'd4, 32'd0, 64'd1000));
    send_request(make_request(OP_END, 32'd3, 32'd4, 32'd0, 3'd4, 32'd0, 64'd1000999));
    send_request(make_request(OP_END, 32'd3, 32'd4, 32'd0, 3'd1, 32'd0, 64'd1001000));
    // filtered kind exactly at the threshold emits
    send_request(make_request(OP_BEGIN, 32'd3, 32'd4, 32'd0, 3'd5, 32'd0, 64'd0));
    send_request(make_request(OP_END, 32'd3, 32'd4, 32'd0, 3'd5, 32'd9, 64'd1000000));
    // all-ones key, kind 7 on an end, widest latency, most negative return code
    send_request(make_request(OP_BEGIN, '1, '1, 32'd0, 3'd7, 32'd0, 64'd0));
    send_request(make_request(OP_END, '1, '1, 32'd0, 3'd7, 32'h8000_0000, '1));
    // key zero is legal for begin and end, but a switch from process zero closes nothing
    send_request(make_request(OP_BEGIN, 32'd0, 32'd0, 32'd0, 3'd6, 32'd0, 64'd5));
    send_request(make_request(OP_SWITCH, 32'd0, 32'd0, 32'd0, 3'd6, 32'd0, 64'd6));
    send_request(make_request(OP_END, 32'd0, 32'd0, 32'd0, 3'd6, 32'h7FFF_FFFF, 64'd2000006));
    // switch: latency equal to the threshold is silent, one above emits
    send_request(make_request(OP_SWITCH, 32'd0, 32'd0, 32'd9, 3'd0, 32'd0, 64'd10));
    send_request(make_request(OP_SWITCH, 32'd9, 32'd0, 32'd0, 3'd0, 32'd0, 64'd1000010));
    send_request(make_request(OP_SWITCH, 32'd9, 32'd0, 32'd9, 3'd0, 32'd0, 64'd1000011));
    send_request(make_request(OP_SWITCH, 32'd9, 32'd0, 32'd9, 3'd0, 32'd0, 64'd2000012));
    // a begin with thread zero is closed by a switch; clock behind gives zero latency
    send_request(make_request(OP_BEGIN, 32'd12, 32'd0, 32'd0, 3'd2, 32'd0, 64'd50));
    send_request(make_request(OP_SWITCH, 32'd12, 32'd0, '1, 3'd2, 32'd0, 64'd5));
    send_request(make_request(OP_SWITCH, '1, 32'd0, 32'd0, 3'd3, 32'd0, '1));
    // thread id is ignored on a switch
    send_request(make_request(OP_SWITCH, 32'd9, 32'hDEAD_BEEF, 32'd0, 3'd1, 32'd3,
                              64'd3000013));
    // unused opcode changes nothing: the following end finds no key
    send_request(make_request(OP_UNUSED, 32'd20, 32'd20, 32'd20, 3'd1, 32'd0, 64'd0));
    send_request(make_request(OP_END, 32'd20, 32'd20, 32'd0, 3'd1, 32'd0, 64'd100));
  endtask

  // random traffic under a range of register settings, extremes included
  task automatic test_config_sweep();
    refresh_pools();
    run_random(PHASE_ITEMS);
    set_config(32'd0, 8'hFF);
    run_random(PHASE_ITEMS);
    set_config('1, 8'hFF);
    run_random(PHASE_ITEMS);
    set_config('1, 8'h00);
    refresh_pools();
    run_random(PHASE_ITEMS);
    set_config(32'd1000, 8'hAA);
    run_random(PHASE_ITEMS);
    set_config($urandom, 8'($urandom));
    refresh_pools();
    run_random(PHASE_ITEMS);
    set_config($urandom_range(0, 5000000), 8'h55);
    run_random(PHASE_ITEMS);
  endtask

  // fill every entry, then drops, overwrite, free and reuse of a slot
  task automatic test_table_full();
    in_item_t    r;
    logic [63:0] key;
    int          i;
    i = 0;
    sender_idles    = 1'b0;
    receiver_stalls = 1'b1;
    while (open_start.num() < TABLE_ENTRIES) begin
      send_request(make_request(OP_BEGIN, 32'hA500_0000 + i, $urandom, 32'd0,
                                3'($urandom_range(0, 7)), 32'd0, advance_clock()));
      i++;
    end
    sender_idles = 1'b1;
    // new keys are dropped, a switch cannot open either
    for (int n = 0; n < 3; n++)
      send_request(make_request(OP_BEGIN, 32'h5A00_0000 + n, 32'd1, 32'd0, 3'd0, 32'd0,
                                advance_clock()));
    send_request(make_request(OP_SWITCH, 32'd0, 32'd0, 32'h5B00_0001, 3'd0, 32'd0,
                              advance_clock()));
    send_request(make_request(OP_END, 32'h5A00_0000, 32'd1, 32'd0, 3'd0, 32'd0,
                              advance_clock()));
    send_request(make_request(OP_SWITCH, 32'h5B00_0001, 32'd0, 32'd0, 3'd0, 32'd0,
                              advance_clock()));
    // an existing key still takes a new start time
    void'(open_start.first(key));
    send_request(make_request(OP_BEGIN, key[63:32], key[31:0], 32'd0, 3'd0, 32'd0,
                              advance_clock()));
    // free entries one by one and reuse one
    for (int n = 0; n < 6; n++) begin
      void'(open_start.first(key));
      r = make_request(OP_END, key[63:32], key[31:0], 32'd0, 3'($urandom_range(0, 7)),
                       $urandom, open_start[key] + pick_elapsed());
      send_request(r);
      if (n == 2) begin
        send_request(make_request(OP_BEGIN, 32'h5C00_0000, 32'd7, 32'd0, 3'd0, 32'd0,
                                  advance_clock()));
        send_request(make_request(OP_END, 32'h5C00_0000, 32'd7, 32'd0, 3'd3, 32'd1,
                                  clock_ns + pick_elapsed()));
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // the clearing pass runs behind req_stall; the drain time covers it
    wait_idle();
    test_register_reset();
    test_directed();
    test_config_sweep();
    test_table_full();
    wait_idle();
    $display("summary: %0d requests under %0d register settings, %0d latency events checked",
             requests_sent, settings_applied, events_checked);
    $display("summary: threshold edges, backward clocks, switches and a full table of %0d",
             TABLE_ENTRIES);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", failures);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
